@@ rtl/core/pwm_table_bilinear_slice_assert.svh @@
// Assertion macros for the top-level RTL file of the interpolation slice
`ifndef PWM_TABLE_BILINEAR_SLICE_ASSERT_SVH
`define PWM_TABLE_BILINEAR_SLICE_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define PTBS_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptbs assertion failed");

// Next-cycle implication, masked while reset is high
`define PTBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptbs assertion failed");

`endif

@@ rtl/core/ptbs_pkg.sv @@
package ptbs_pkg;

  // Table geometry
  localparam int PHASE_ROWS = 16;
  localparam int MOD_ROWS   = 16;
  localparam int POINTS     = 64;
  localparam int ROW_W      = $clog2(PHASE_ROWS);
  localparam int MROW_W     = $clog2(MOD_ROWS);
  localparam int PT_W       = $clog2(POINTS);
  localparam int ADDR_W     = ROW_W + MROW_W + PT_W;
  localparam int DEPTH      = PHASE_ROWS * MOD_ROWS * POINTS;
  localparam int VAL_W      = 16;

  // Configuration register widths
  localparam int PCNT_W = 5;
  localparam int MCNT_W = 5;
  localparam int TCNT_W = 7;

  // Fixed point
  localparam logic [15:0] MOD_ONE   = 16'd32768;
  localparam logic [17:0] PHASE_ONE = 18'd65536;
  localparam int          LERP_W    = 34;
  localparam int          SUM_W     = 52;
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(64'd1 << 30);

  // Queues
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
  localparam int OPTR_W     = $clog2(OUTQ_DEPTH);

  // Item kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_PHASE_COUNT = 2'd0;
  localparam logic [1:0] REG_MOD_COUNT   = 2'd1;
  localparam logic [1:0] REG_POINT_COUNT = 2'd2;

  typedef enum logic {BK_IDLE, BK_QUERY} back_state_t;

  typedef struct packed {
    logic [PCNT_W-1:0] phase_count;
    logic [MCNT_W-1:0] mod_count;
    logic [TCNT_W-1:0] point_count;
  } cfg_t;

  // One classified item in the command queue
  typedef struct packed {
    logic              cmd;
    logic [ROW_W-1:0]  wr_phase;
    logic [MROW_W-1:0] wr_mod;
    logic [PT_W-1:0]   wr_point;
    logic [VAL_W-1:0]  wr_value;
    logic [ROW_W-1:0]  pl;
    logic [ROW_W-1:0]  ph;
    logic [MROW_W-1:0] ml;
    logic [MROW_W-1:0] mh;
    logic [15:0]       mf;
    logic [16:0]       pf;
    logic [TCNT_W-1:0] nt;
  } cmd_t;

  // Tag travelling with each corner read
  typedef struct packed {
    logic            valid;
    logic [1:0]      corner;
    logic [PT_W-1:0] pt;
    logic            last;
  } tag_t;

  typedef struct packed {
    logic       busy;
    logic [2:0] credit;
  } bk_status_t;

endpackage

@@ rtl/core/ptbs_front.sv @@
module ptbs_front (
  input  ptbs_pkg::cfg_t cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [63:0]    s_tdata,  // write_phase_row, write_mod_row, write_point,
                                   // write_value, modulation, start_phase, pad
  input  logic           s_tuser,  // command
  input  logic           q_full,
  output logic           q_push,
  output ptbs_pkg::cmd_t q_data
);
  import ptbs_pkg::*;

  logic [PCNT_W-1:0] np;
  logic [MCNT_W-1:0] nm;
  logic [TCNT_W-1:0] nt;
  logic [15:0]       mi;
  logic [15:0]       ph;
  logic [20:0]       m_scaled;
  logic [20:0]       p_scaled;
  logic [5:0]        m_fl;
  logic [5:0]        m_lim;
  logic [4:0]        p_fl;
  logic [4:0]        p_lim;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Counts in force: zero acts as one, capped at the table size
  always_comb begin
    np = (cfg.phase_count == '0) ? PCNT_W'(1) :
         (cfg.phase_count > PCNT_W'(PHASE_ROWS)) ? PCNT_W'(PHASE_ROWS) : cfg.phase_count;
    nm = (cfg.mod_count == '0) ? MCNT_W'(1) :
         (cfg.mod_count > MCNT_W'(MOD_ROWS)) ? MCNT_W'(MOD_ROWS) : cfg.mod_count;
    nt = (cfg.point_count == '0) ? TCNT_W'(1) :
         (cfg.point_count > TCNT_W'(POINTS)) ? TCNT_W'(POINTS) : cfg.point_count;
  end

  // Locate the low rows and fractions of both coordinates
  always_comb begin
    mi = (s_tdata[45:30] > MOD_ONE) ? MOD_ONE : s_tdata[45:30];
    ph = s_tdata[61:46];
    m_scaled = 21'(mi) * 21'(nm - MCNT_W'(1));
    p_scaled = 21'(ph) * 21'(np - PCNT_W'(1));
    m_lim    = 6'(nm - MCNT_W'(2));
    p_lim    = 5'(np - PCNT_W'(2));
    m_fl     = m_scaled[20:15];
    if (m_fl > m_lim) m_fl = m_lim;
    p_fl     = p_scaled[20:16];
    if (p_fl > p_lim) p_fl = p_lim;

    q_data          = '0;
    q_data.cmd      = s_tuser;
    q_data.wr_phase = s_tdata[3:0];
    q_data.wr_mod   = s_tdata[7:4];
    q_data.wr_point = s_tdata[13:8];
    q_data.wr_value = s_tdata[29:14];
    q_data.nt       = nt;
    if (nm > MCNT_W'(1)) begin
      q_data.ml = MROW_W'(m_fl);
      q_data.mh = MROW_W'(m_fl) + MROW_W'(1);
      q_data.mf = 16'(m_scaled - {m_fl, 15'b0});
    end
    if (np > PCNT_W'(1)) begin
      q_data.pl = ROW_W'(p_fl);
      q_data.ph = ROW_W'(p_fl) + ROW_W'(1);
      q_data.pf = 17'(p_scaled - {p_fl, 16'b0});
    end
  end

endmodule

@@ rtl/core/ptbs_fifo.sv @@
module ptbs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ptbs_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ptbs_pkg::cmd_t pop_data
);
  import ptbs_pkg::*;

  cmd_t              entry [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(CMDQ_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entry[rp];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push && !full) wp <= wp + QPTR_W'(1);
      if (pop && valid)  rp <= rp + QPTR_W'(1);
      case ({push && !full, pop && valid})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push && !full) entry[wp] <= push_data;
  end

endmodule

@@ rtl/core/ptbs_back.sv @@
module ptbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ptbs_pkg::cmd_t       q_data,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,  // point_index, interpolated_value, pad
  output logic                 m_tlast,
  output ptbs_pkg::bk_status_t status
);
  import ptbs_pkg::*;

  // Table store, undefined until written
  logic [VAL_W-1:0] mem [DEPTH];

  back_state_t state;
  back_state_t state_next;
  cmd_t        qry;
  logic [PT_W-1:0]   point;
  logic [1:0]        corner;
  logic [2:0]        credit;
  logic              issue;
  logic              mem_we;
  logic              last_pt;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic signed [VAL_W-1:0] rd_data;
  tag_t t1;
  tag_t t2;
  tag_t t3;

  logic [16:0]              w_lerp;
  logic signed [LERP_W-1:0] mul;
  logic signed [LERP_W-1:0] prod1;
  logic signed [LERP_W-1:0] lerp_a;
  logic signed [LERP_W-1:0] lerp_b;
  logic [17:0]              w_lo;
  logic [16:0]              pf_s;
  logic signed [SUM_W-1:0]  phase_lo;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [20:0]       q_full;
  logic signed [VAL_W-1:0]  q_sat;
  logic                     push_out;
  logic                     out_pop;

  logic [PT_W-1:0]   ov_pt   [OUTQ_DEPTH];
  logic [VAL_W-1:0]  ov_val  [OUTQ_DEPTH];
  logic              ov_last [OUTQ_DEPTH];
  logic [OPTR_W-1:0] owp;
  logic [OPTR_W-1:0] orp;
  logic [OPTR_W:0]   ocnt;

  assign last_pt = ({1'b0, point} == (qry.nt - TCNT_W'(1)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (q_valid && q_data.cmd == CMD_QUERY) state_next = BK_QUERY;
      BK_QUERY: if (issue && corner == 2'd3 && last_pt) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs: a point starts only with room left in the output queue
  always_comb begin
    q_pop  = 1'b0;
    issue  = 1'b0;
    mem_we = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop  = q_valid;
        mem_we = q_valid && q_data.cmd == CMD_WRITE;
      end
      BK_QUERY: issue = (corner != 2'd0) || (credit < 3'(OUTQ_DEPTH));
      default: ;
    endcase
  end

  // Corner order: (pl,ml) (pl,mh) (ph,ml) (ph,mh)
  assign raddr = {corner[1] ? qry.ph : qry.pl, corner[0] ? qry.mh : qry.ml, point};
  assign waddr = {q_data.wr_phase, q_data.wr_mod, q_data.wr_point};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      point  <= '0;
      corner <= '0;
    end else begin
      state <= state_next;
      if (q_pop && q_data.cmd == CMD_QUERY) begin
        point  <= '0;
        corner <= '0;
      end else if (issue) begin
        corner <= corner + 2'd1;
        if (corner == 2'd3) point <= point + PT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.cmd == CMD_QUERY) qry <= q_data;
  end

  // Store access
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= q_data.wr_value;
    if (issue)  rd_data <= mem[raddr];
  end

  // Points in flight or waiting at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      case ({issue && corner == 2'd0, out_pop})
        2'b10:   credit <= credit + 3'd1;
        2'b01:   credit <= credit - 3'd1;
        default: credit <= credit;
      endcase
    end
  end

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1.valid  <= issue;
      t1.corner <= corner;
      t1.pt     <= point;
      t1.last   <= last_pt;
      t2        <= t1;
      t3        <= t2;
    end
  end

  // Modulation lerp, one corner per cycle while corner reads are not paused, on a shared multiplier
  always_comb begin
    w_lerp = t1.corner[0] ? {1'b0, qry.mf} : (17'(MOD_ONE) - {1'b0, qry.mf});
    mul    = LERP_W'(rd_data) * LERP_W'($signed({1'b0, w_lerp}));
    w_lo   = PHASE_ONE - {1'b0, qry.pf};
  end

  always_ff @(posedge clk) begin
    if (t1.valid) begin
      unique case (t1.corner)
        2'd0: prod1 <= mul;
        2'd1: lerp_a <= prod1 + mul;
        2'd2: begin
          prod1    <= mul;
          phase_lo <= SUM_W'(lerp_a) * SUM_W'($signed({1'b0, w_lo}));
        end
        2'd3: begin
          lerp_b <= prod1 + mul;
          pf_s   <= qry.pf;
        end
        default: ;
      endcase
    end
    if (t2.valid && t2.corner == 2'd3)
      sum <= phase_lo + SUM_W'(lerp_b) * SUM_W'($signed({1'b0, pf_s}));
  end

  // Round half up and saturate
  always_comb begin
    rnd    = sum + $signed(ROUND_BIAS);
    q_full = rnd[SUM_W-1:31];
    if (q_full > 21'sd32767)       q_sat = 16'sd32767;
    else if (q_full < -21'sd32768) q_sat = -16'sd32768;
    else                           q_sat = q_full[VAL_W-1:0];
  end

  assign push_out = t3.valid && t3.corner == 2'd3;
  assign out_pop  = m_tvalid && m_tready;

  // Output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (push_out) owp <= owp + OPTR_W'(1);
      if (out_pop)  orp <= orp + OPTR_W'(1);
      case ({push_out, out_pop})
        2'b10:   ocnt <= ocnt + (OPTR_W+1)'(1);
        2'b01:   ocnt <= ocnt - (OPTR_W+1)'(1);
        default: ocnt <= ocnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_out) begin
      ov_pt[owp]   <= t3.pt;
      ov_val[owp]  <= q_sat;
      ov_last[owp] <= t3.last;
    end
  end

  assign m_tvalid      = (ocnt != '0);
  assign m_tdata       = {2'b0, ov_val[orp], ov_pt[orp]};
  assign m_tlast       = ov_last[orp];
  assign status.busy   = (state != BK_IDLE) || (credit != '0);
  assign status.credit = credit;

endmodule

@@ rtl/core/pwm_table_bilinear_slice.sv @@
// Bilinear slice lookup over a 16 x 16 x 64 table of signed Q1.15 PWM
// intersection words. A write beat (tuser 0) stores one word and gives no
// output; a query beat (tuser 1) gives point_count output beats, points 0 up
// to point_count-1, tlast on the final one (a count of zero acts as one, and
// counts are capped at the table size). Input beats are classified and
// queued (four entries), so the input side keeps taking beats while a query
// runs, until the queue is full. The table store has a single read port and
// each point needs four corner reads. The back end takes an item from the
// queue; a write is stored as it is taken, and a query then reads the four
// corners of each point in turn. A point's result passes through the read
// register, the lerp register and the sum register into the output queue
// after its last corner read. The output holds at most four points in
// flight or waiting, beyond which the corner reads pause. The store has no
// reset: only query rows and points that were written give defined values.
// Counts are set through the APB port at 0x0 (phase rows), 0x4 (modulation
// rows), 0x8 (points); the user must see that they are written only while
// the block is idle, since the block itself does not enforce this.
`include "pwm_table_bilinear_slice_assert.svh"

module pwm_table_bilinear_slice (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // write_phase_row[3:0], write_mod_row[7:4],
                                // write_point[13:8], write_value[29:14],
                                // modulation[45:30], start_phase[61:46], pad
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // point_index[5:0], interpolated_value[21:6], pad
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptbs_pkg::*;

  cfg_t       cfg;
  logic       cfg_we;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  cmd_t       q_in;
  cmd_t       q_out;
  bk_status_t bk_status;

  // Register file
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_count <= PCNT_W'(PHASE_ROWS);
      cfg.mod_count   <= MCNT_W'(MOD_ROWS);
      cfg.point_count <= TCNT_W'(POINTS);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_PHASE_COUNT: cfg.phase_count <= pwdata[PCNT_W-1:0];
        REG_MOD_COUNT:   cfg.mod_count   <= pwdata[MCNT_W-1:0];
        REG_POINT_COUNT: cfg.point_count <= pwdata[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PHASE_COUNT: prdata = 32'(cfg.phase_count);
      REG_MOD_COUNT:   prdata = 32'(cfg.mod_count);
      REG_POINT_COUNT: prdata = 32'(cfg.point_count);
      default:         prdata = '0;
    endcase
  end

  ptbs_front u_front (
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ptbs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  ptbs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (bk_status)
  );

  // Checks
  `PTBS_ASSERT(a_push_room, clk, rst, q_push, !q_full)
  `PTBS_ASSERT(a_credit_bound, clk, rst, bk_status.busy, bk_status.credit <= 3'(OUTQ_DEPTH))
  `PTBS_ASSERT(a_out_needs_credit, clk, rst, m_tvalid, bk_status.credit != 3'd0)
  `PTBS_ASSERT_NEXT(a_cfg_phase, clk, rst, cfg_we && paddr[3:2] == REG_PHASE_COUNT, cfg.phase_count == $past(pwdata[PCNT_W-1:0]))

endmodule
